// ===== hw/rtl/frame_timestamp_smoother_top_macros.svh =====
// Assertion macros shared by the frame timestamp smoother RTL.
`ifndef FRAME_TIMESTAMP_SMOOTHER_TOP_MACROS_SVH
`define FRAME_TIMESTAMP_SMOOTHER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Checks that prop holds at every clock edge outside reset.
`define FTSS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checks that expr is never true at a clock edge outside reset.
`define FTSS_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define FTSS_ASSERT(label, clk, rst_n, prop, msg)
`define FTSS_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

// ===== hw/rtl/ftss_pkg.sv =====
// Types and constants of the frame timestamp smoother.
package ftss_pkg;

    localparam logic [19:0] PERIOD_MAX   = 20'd1000000;
    localparam logic [19:0] PERIOD_RESET = 20'd10000;

    // Reciprocal of ten scaled by 2^27; exact for every filter sum below 2^26.
    localparam logic [23:0] DIV10_RECIP  = 24'hCC_CCCD;

    // Iteration count of the shared divider.
    localparam logic [6:0] DIV_ITERS_WIDE = 7'd64;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_EXP   = 10'b00_0000_0010,
        S_INIT  = 10'b00_0000_0100,
        S_GAP   = 10'b00_0000_1000,
        S_CHK   = 10'b00_0001_0000,
        S_DIV   = 10'b00_0010_0000,
        S_FILT  = 10'b00_0100_0000,
        S_DIV10 = 10'b00_1000_0000,
        S_MUL   = 10'b01_0000_0000,
        S_OUT   = 10'b10_0000_0000
    } t_state;

    typedef struct packed {
        logic        start;
        logic [6:0]  iters;
        logic [63:0] dividend;
        logic [32:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ===== hw/rtl/ftss_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
module ftss_div
    import ftss_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_div_req    i_req,
    output t_div_stat   o_stat,
    output logic [63:0] o_quotient
);

    logic [6:0]  r_cnt;
    logic        r_done;
    logic [32:0] r_rem;
    logic [63:0] r_quo;
    logic [32:0] r_divisor;

    logic [33:0] w_rem_sh;
    logic [33:0] w_diff;
    logic        w_fit;

    // The dividend is loaded left aligned; after N steps the quotient sits in the low N bits.
    assign w_rem_sh = {r_rem, r_quo[63]};
    assign w_diff   = w_rem_sh - {1'b0, r_divisor};
    assign w_fit    = (w_rem_sh >= {1'b0, r_divisor});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_cnt <= i_req.iters;
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem     <= '0;
            r_quo     <= i_req.dividend;
            r_divisor <= i_req.divisor;
        end else if (r_cnt != '0) begin
            r_rem <= w_fit ? w_diff[32:0] : w_rem_sh[32:0];
            r_quo <= {r_quo[62:0], w_fit};
        end
    end

    assign o_stat.busy = (r_cnt != '0);
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule

// ===== hw/rtl/frame_timestamp_smoother_top.sv =====
// Top level of the frame timestamp smoother: sequencer, filter state and stream ports.
//
// One frame enters on the s_axis channel: arrival time, latency and frame number.
// One result leaves on the m_axis channel for every frame: smoothed timestamp, filtered
// period, dropped frames now and in total, frame total, and a duplicate flag on tuser.
// The nominal period is written through i_cfg_wr_en / i_cfg_wr_data; the user must write
// it only while no frame is in flight, which the block itself does not enforce. It is
// loaded into the filter on the first frame after reset. A frame is accepted in S_IDLE and
// then runs through a small sequencer that uses one restoring divider for 64 steps to form
// the time step; the divide by ten of the period filter is a reciprocal multiplication.
// After S_EXP, S_INIT, S_GAP and S_CHK a normal frame passes S_DIV, S_FILT, S_DIV10 and
// S_MUL to S_OUT, while a duplicate frame skips the divider and goes from S_CHK to S_OUT.
// s_axis_tready is high only while the sequencer is idle, so one frame is handled at a
// time. The result waits in an output register; the next frame may be accepted and
// worked on while it waits, and its result is held back until the receiver takes the
// earlier one, which stalls the input. Nothing is lost when the receiver stalls.
// Reset (synchronous, active low) clears the filter history, counters and the first
// frame flag, and sets the nominal period to 10000 microseconds.
`include "frame_timestamp_smoother_top_macros.svh"

module frame_timestamp_smoother_top
    import ftss_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [19:0]  i_cfg_wr_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // arrival[62:0], latency[94:63], frame_num[125:95], zero pad
    input  logic [127:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // timestamp[63:0], period[83:64], dropped_now[114:84],
    // dropped_total[146:115], frame_total[178:147], zero pad
    output logic [183:0] m_axis_tdata,
    // duplicate
    output logic         m_axis_tuser
);

    t_state      r_state;
    t_state      n_state;

    logic [19:0] r_nominal;
    logic [62:0] r_arrival;
    logic [31:0] r_latency;
    logic [30:0] r_fn;
    logic [63:0] r_expected;
    logic [63:0] r_last_time;
    logic [31:0] r_last_num;
    logic [19:0] r_period;
    logic        r_seen;
    logic [31:0] r_drop_cnt;
    logic [31:0] r_frame_cnt;
    logic [32:0] r_gap;
    logic [63:0] r_diff;
    logic        r_dup;
    logic [19:0] r_step;
    logic [23:0] r_filt_sum;
    logic [51:0] r_prod;

    logic         r_m_valid;
    logic [183:0] r_m_data;
    logic         r_m_dup;

    t_div_req    w_div_req;
    t_div_stat   w_div_stat;
    logic [63:0] w_quo;

    logic        w_accept;
    logic        w_out_free;
    logic [19:0] w_nom_clamp;
    logic [64:0] w_diff_full;
    logic [63:0] w_diff_sat;
    logic        w_gap_dup;
    logic [23:0] w_filt_sum;
    logic [47:0] w_tenth;
    logic [64:0] w_time_sum;
    logic [31:0] w_gap_m1;
    logic [32:0] w_drop_sum;
    logic [32:0] w_frame_sum;
    logic [30:0] w_drop_now;

    ftss_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_div_req),
        .o_stat     (w_div_stat),
        .o_quotient (w_quo)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_m_valid || m_axis_tready;

    always_comb begin
        if (r_nominal == '0) begin
            w_nom_clamp = 20'd1;
        end else if (r_nominal > PERIOD_MAX) begin
            w_nom_clamp = PERIOD_MAX;
        end else begin
            w_nom_clamp = r_nominal;
        end
    end

    // Time difference with saturation at the signed 64-bit limits.
    assign w_diff_full = {r_expected[63], r_expected} - {r_last_time[63], r_last_time};
    always_comb begin
        unique case (w_diff_full[64:63])
            2'b01:   w_diff_sat = {1'b0, {63{1'b1}}};
            2'b10:   w_diff_sat = {1'b1, 63'd0};
            default: w_diff_sat = w_diff_full[63:0];
        endcase
    end

    assign w_gap_dup  = r_gap[32] || (r_gap == '0);
    assign w_filt_sum = {1'b0, r_period, 3'b000} + {4'b0000, r_period} + {4'b0000, r_step};
    assign w_tenth    = r_filt_sum * DIV10_RECIP;
    assign w_time_sum = {r_last_time[63], r_last_time} + {13'd0, r_prod};
    assign w_gap_m1   = r_gap[31:0] - 32'd1;
    assign w_drop_sum = {1'b0, r_drop_cnt} + {2'b00, w_gap_m1[30:0]};
    assign w_frame_sum = {1'b0, r_frame_cnt} + {1'b0, r_gap[31:0]};
    assign w_drop_now = (r_dup || !r_seen) ? 31'd0 : w_gap_m1[30:0];

    always_comb begin
        w_div_req.start    = 1'b0;
        w_div_req.iters    = DIV_ITERS_WIDE;
        w_div_req.dividend = '0;
        w_div_req.divisor  = r_gap;
        if (r_state == S_CHK) begin
            w_div_req.start = !w_gap_dup;
            // A negative difference gives a step that clamps to zero.
            w_div_req.dividend = r_diff[63] ? 64'd0 : r_diff;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_accept) n_state = S_EXP;
            S_EXP:   n_state = S_INIT;
            S_INIT:  n_state = S_GAP;
            S_GAP:   n_state = S_CHK;
            S_CHK:   n_state = w_gap_dup ? S_OUT : S_DIV;
            S_DIV:   if (w_div_stat.done) n_state = S_FILT;
            S_FILT:  n_state = S_DIV10;
            S_DIV10: n_state = S_MUL;
            S_MUL:   n_state = S_OUT;
            S_OUT:   if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_nominal   <= PERIOD_RESET;
            r_last_time <= '0;
            r_last_num  <= '0;
            r_period    <= PERIOD_RESET;
            r_seen      <= 1'b0;
            r_drop_cnt  <= '0;
            r_frame_cnt <= '0;
            r_m_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_nominal <= i_cfg_wr_data;
            end
            if ((r_state == S_OUT) && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_EXP: begin
                    if (!r_seen) begin
                        r_period <= w_nom_clamp;
                    end
                end
                S_INIT: begin
                    if (!r_seen) begin
                        r_last_time <= r_expected - {44'd0, r_period};
                        r_last_num  <= {1'b0, r_fn} - 32'd1;
                    end
                end
                S_DIV10: begin
                    r_period <= w_tenth[46:27];
                end
                S_MUL: begin
                    // The product is registered in this state; the sum follows in S_OUT.
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_seen <= 1'b1;
                        if (!r_dup) begin
                            r_last_time <= (w_time_sum[64:63] == 2'b01) ?
                                           {1'b0, {63{1'b1}}} : w_time_sum[63:0];
                            r_last_num  <= {1'b0, r_fn};
                            if (r_seen) begin
                                r_drop_cnt  <= w_drop_sum[32] ? '1 : w_drop_sum[31:0];
                                r_frame_cnt <= w_frame_sum[32] ? '1 : w_frame_sum[31:0];
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_arrival <= s_axis_tdata[62:0];
            r_latency <= s_axis_tdata[94:63];
            r_fn      <= s_axis_tdata[125:95];
        end
        if (r_state == S_EXP) begin
            r_expected <= {1'b0, r_arrival} - {32'd0, r_latency};
        end
        if (r_state == S_GAP) begin
            r_gap  <= {2'b00, r_fn} - {r_last_num[31], r_last_num};
            r_diff <= w_diff_sat;
        end
        if (r_state == S_CHK) begin
            r_dup <= w_gap_dup;
        end
        if ((r_state == S_DIV) && w_div_stat.done) begin
            r_step <= ((w_quo[63:20] != '0) || (w_quo[19:0] > PERIOD_MAX)) ?
                      PERIOD_MAX : w_quo[19:0];
        end
        if (r_state == S_FILT) begin
            r_filt_sum <= w_filt_sum;
        end
        if (r_state == S_MUL) begin
            r_prod <= r_gap[31:0] * r_period;
        end
    end

    // Output register; the payload is assembled from the state as it stands after the frame.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && w_out_free) begin
            r_m_dup  <= r_dup;
            r_m_data <= {5'd0,
                         (r_dup || !r_seen) ? r_frame_cnt :
                             (w_frame_sum[32] ? 32'hFFFF_FFFF : w_frame_sum[31:0]),
                         (r_dup || !r_seen) ? r_drop_cnt :
                             (w_drop_sum[32] ? 32'hFFFF_FFFF : w_drop_sum[31:0]),
                         w_drop_now,
                         r_period,
                         r_dup ? r_last_time :
                             ((w_time_sum[64:63] == 2'b01) ?
                              {1'b0, {63{1'b1}}} : w_time_sum[63:0])};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_dup;

    `FTSS_ASSERT(a_div_owner, i_clk, i_rst_n, w_div_stat.busy |-> (r_state == S_DIV), "divider busy outside the divide state")
    `FTSS_ASSERT(a_ready_div_idle, i_clk, i_rst_n, s_axis_tready |-> !w_div_stat.busy, "input ready while the divider runs")
    `FTSS_ASSERT(a_dup_no_drop, i_clk, i_rst_n, (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[114:84] == '0), "duplicate frame reports dropped frames")
    `FTSS_ASSERT_NEVER(a_period_max, i_clk, i_rst_n, r_period > PERIOD_MAX, "filtered period above its maximum")

endmodule

// ===== test/frame_timestamp_smoother_checker.sv =====
// Checker for the frame timestamp smoother: predicts each result and compares it.
module frame_timestamp_smoother_checker
    import ftss_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [19:0]  i_cfg_wr_data,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    // arrival[62:0], latency[94:63], frame_num[125:95], zero pad
    input  logic [127:0] i_s_tdata,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    // timestamp[63:0], period[83:64], dropped_now[114:84],
    // dropped_total[146:115], frame_total[178:147], zero pad
    input  logic [183:0] i_m_tdata,
    // duplicate
    input  logic         i_m_tuser,
    output int           o_fail_count,
    output int           o_pending
);

    localparam longint TIME_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam longint TIME_MIN  = {1'b1, 63'b0};
    localparam longint COUNT_MAX = 64'h0000_0000_FFFF_FFFF;
    localparam longint STEP_MAX  = PERIOD_MAX;

    typedef struct {
        logic [63:0] stamp_usec;
        logic [19:0] period;
        logic [30:0] dropped_now;
        logic [31:0] dropped_total;
        logic [31:0] frame_total;
        logic        duplicate;
    } t_stamp;

    t_stamp      stamps_q[$];
    logic [19:0] nominal;
    longint      hist_time;
    logic [31:0] hist_number;
    logic [19:0] filt_period;
    bit          seen;
    logic [31:0] drop_sum;
    logic [31:0] frame_sum;
    int          fails = 0;

    function automatic logic [31:0] sat_count(input logic [31:0] acc, input longint add);
        longint s;
        s = longint'({32'b0, acc}) + add;
        return (s > COUNT_MAX) ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // Advances the filter state by one frame request and returns the result it yields.
    function automatic t_stamp smooth_frame(input logic [127:0] req);
        logic [62:0]       arrival;
        logic [31:0]       latency;
        logic [30:0]       fn;
        longint            expected_t;
        longint            last_s;
        longint            gap;
        longint            step_v;
        longint            advance;
        longint            p;
        logic signed [64:0] diff;
        t_stamp            r;
        arrival    = req[62:0];
        latency    = req[94:63];
        fn         = req[125:95];
        expected_t = longint'({1'b0, arrival}) - longint'({32'b0, latency});
        if (!seen) begin
            p = longint'({44'b0, nominal});
            if (p < 1) begin
                p = 1;
            end else if (p > STEP_MAX) begin
                p = STEP_MAX;
            end
            filt_period = p[19:0];
            hist_time   = expected_t - p;
            hist_number = {1'b0, fn} - 32'd1;
        end
        last_s        = $signed(hist_number);
        gap           = longint'({33'b0, fn}) - last_s;
        r.dropped_now = '0;
        r.duplicate   = (gap <= 0);
        if (gap <= 0) begin
            r.stamp_usec = hist_time;
        end else begin
            // The difference is formed one bit wider and then clamped to 64 bits.
            diff = expected_t - hist_time;
            if (diff > TIME_MAX) begin
                step_v = TIME_MAX;
            end else if (diff < TIME_MIN) begin
                step_v = TIME_MIN;
            end else begin
                step_v = diff[63:0];
            end
            step_v = step_v / gap;
            if (step_v < 0) begin
                step_v = 0;
            end else if (step_v > STEP_MAX) begin
                step_v = STEP_MAX;
            end
            p           = (9 * longint'({44'b0, filt_period}) + step_v) / 10;
            filt_period = p[19:0];
            advance     = gap * longint'({44'b0, filt_period});
            hist_time   = (hist_time > TIME_MAX - advance) ? TIME_MAX : hist_time + advance;
            if (seen) begin
                r.dropped_now = 31'(gap - 1);
                drop_sum      = sat_count(drop_sum, gap - 1);
                frame_sum     = sat_count(frame_sum, gap);
            end
            hist_number  = {1'b0, fn};
            r.stamp_usec = hist_time;
        end
        seen            = 1'b1;
        r.period        = filt_period;
        r.dropped_total = drop_sum;
        r.frame_total   = frame_sum;
        return r;
    endfunction

    task automatic check_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_stamp want;
        if (!i_rst_n) begin
            nominal     = PERIOD_RESET;
            hist_time   = 0;
            hist_number = '0;
            filt_period = PERIOD_RESET;
            seen        = 1'b0;
            drop_sum    = '0;
            frame_sum   = '0;
            stamps_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                nominal = i_cfg_wr_data;
            end
            if (i_s_tvalid && i_s_tready) begin
                stamps_q.insert(stamps_q.size(), smooth_frame(i_s_tdata));
            end
            if (i_m_tvalid && i_m_tready) begin
                if (stamps_q.size() == 0) begin
                    $display("%0t: result with no frame waiting, expected none actual %h",
                             $time, i_m_tdata);
                    fails++;
                end else begin
                    want = stamps_q.pop_front();
                    check_field("timestamp", want.stamp_usec, i_m_tdata[63:0]);
                    check_field("period_usec", want.period, i_m_tdata[83:64]);
                    check_field("dropped_now", want.dropped_now, i_m_tdata[114:84]);
                    check_field("dropped_total", want.dropped_total, i_m_tdata[146:115]);
                    check_field("frame_total", want.frame_total, i_m_tdata[178:147]);
                    check_field("duplicate", want.duplicate, i_m_tuser);
                end
            end
        end
        o_pending    <= stamps_q.size();
        o_fail_count <= fails;
    end

endmodule

// ===== test/frame_timestamp_smoother_top_tb.sv =====
// Testbench top for the frame timestamp smoother: clock, reset, frame stimulus and verdict.
module frame_timestamp_smoother_top_tb
    import ftss_pkg::*;
();

    localparam int     WATCHDOG_LIMIT = 4000;
    localparam int     HOLD_CYCLES    = 400;
    localparam int     DRAIN_CYCLES   = 200;
    localparam int     PHASE_FRAMES   = 645;
    localparam longint TIME_MAX       = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam longint CURSOR_MAX     = TIME_MAX - 64'h2_0000_0000;

    logic         clk         = 1'b0;
    logic         rst_n       = 1'b0;
    logic         cfg_wr_en   = 1'b0;
    logic [19:0]  cfg_wr_data = '0;
    logic         s_tvalid    = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata     = '0;
    logic         m_tvalid;
    logic         m_tready    = 1'b0;
    logic [183:0] m_tdata;
    logic         m_tuser;

    int     fail_count;
    int     stamps_pending;
    int     tx_idle_pct = 38;
    int     rx_idle_pct = 70;
    bit     hold_req    = 1'b0;
    bit     hold_done   = 1'b0;
    int     hold_left   = 0;
    int     quiet_cycles = 0;
    longint next_fn      = 0;
    longint clock_cursor = 0;
    int     src_period   = 10000;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    frame_timestamp_smoother_top i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser)
    );

    frame_timestamp_smoother_checker i_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tuser     (m_tuser),
        .o_fail_count  (fail_count),
        .o_pending     (stamps_pending)
    );

    // Receiver: random back-pressure, plus one long hold-off when requested.
    always @(posedge clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    function automatic logic [62:0] rand_time();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[62:0];
    endfunction

    // Moves the frame number and the source clock forward by a number of frames.
    function automatic void advance_cursor(input longint gap);
        next_fn += gap;
        if (clock_cursor > CURSOR_MAX - gap * src_period) begin
            clock_cursor = CURSOR_MAX;
        end else begin
            clock_cursor += gap * src_period;
        end
    endfunction

    task automatic send_frame(input logic [62:0] arrival, input logic [31:0] latency,
                              input logic [30:0] fn);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b0, fn, latency, arrival};
        do @(posedge clk); while (!s_tready);
    endtask

    // A frame that follows the source clock with jitter, or with scrambled times.
    task automatic send_timed(input longint gap, input bit scramble);
        longint      arrival;
        logic [31:0] latency;
        advance_cursor(gap);
        if (scramble) begin
            arrival = longint'(rand_time());
            latency = $urandom;
        end else begin
            latency = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 200000);
            arrival = clock_cursor + longint'($urandom_range(0, src_period / 4))
                      - src_period / 8 + longint'({32'b0, latency});
            if (arrival < 0) begin
                arrival = 0;
            end
        end
        send_frame(arrival[62:0], latency, next_fn[30:0]);
    endtask

    // A frame whose number does not move forward, so it must be flagged duplicate.
    task automatic send_repeat(input longint back);
        longint fn;
        fn = (next_fn > back) ? next_fn - back : 0;
        send_frame(rand_time(), $urandom, fn[30:0]);
    endtask

    task automatic random_frame();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 66) begin
            send_timed(1, 1'b0);
        end else if (pick < 78) begin
            send_timed($urandom_range(2, 6), 1'b0);
        end else if (pick < 81) begin
            send_timed($urandom_range(7, 2000), 1'b0);
        end else if (pick < 82) begin
            send_timed($urandom_range(2001, 1 << 20), 1'b0);
        end else if (pick < 87) begin
            send_timed(0, 1'b0);
        end else if (pick < 91) begin
            send_repeat(0);
        end else if (pick < 95) begin
            send_repeat($urandom_range(1, 1000));
        end else begin
            send_timed(1, 1'b1);
        end
    endtask

    task automatic write_period(input logic [19:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic drain();
        do @(posedge clk); while (stamps_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial begin
        logic [19:0] first_period;
        bit          high_base;
        case ($urandom_range(0, 4))
            0: first_period = '0;
            1: first_period = 20'd1;
            2: first_period = PERIOD_MAX;
            3: first_period = 20'hFFFFF;
            default: first_period = 20'($urandom_range(2, 999999));
        endcase
        // Either the source clock sits just below the top of the time range, so the
        // timestamp sum can saturate, or it starts below zero, so the difference can.
        high_base  = 1'($urandom_range(0, 1));
        src_period = $urandom_range(500, 50000);
        if (high_base) begin
            clock_cursor = CURSOR_MAX - 64'h100_0000_0000 - longint'($urandom);
        end else begin
            clock_cursor = -longint'($urandom_range(1, 5000));
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        write_period(first_period);

        // Directed frames: first frame at number zero, extreme times, duplicates.
        send_timed(0, 1'b0);
        advance_cursor(1);
        send_frame('1, '0, next_fn[30:0]);
        send_frame('1, '1, next_fn[30:0]);
        send_frame('0, '1, 31'd0);
        advance_cursor(1);
        send_frame('0, '1, next_fn[30:0]);
        repeat (4) send_timed(1, 1'b0);
        send_timed(2, 1'b0);
        send_timed(3, 1'b0);
        send_timed(100, 1'b0);
        send_timed(0, 1'b0);
        send_timed(1 << 16, 1'b0);
        repeat (4) send_timed(1, 1'b0);

        repeat (PHASE_FRAMES) random_frame();
        s_tvalid <= 1'b0;
        drain();
        write_period(PERIOD_MAX);
        write_period(20'hFFFFF);
        tx_idle_pct = 70;
        rx_idle_pct <= 38;
        src_period  = $urandom_range(500, 50000);
        repeat (PHASE_FRAMES) random_frame();

        s_tvalid <= 1'b0;
        drain();
        write_period(20'd1);
        write_period('0);
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        hold_req    <= 1'b1;
        src_period  = $urandom_range(500, 50000);
        repeat (PHASE_FRAMES) random_frame();

        // Huge gaps that push the frame number into its top bit and up to its maximum.
        send_timed(longint'(1 << 30) + $urandom_range(0, 1 << 20), 1'b0);
        repeat (2) send_timed(1, 1'b0);
        send_timed(longint'(31'h7FFF_FFFF) - 3 - next_fn, 1'b0);
        repeat (3) send_timed(1, 1'b0);
        send_repeat(next_fn);
        send_timed(0, 1'b0);

        s_tvalid <= 1'b0;
        drain();
        if (fail_count == 0 && stamps_pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/ftss_pkg.sv
hw/rtl/ftss_div.sv
hw/rtl/frame_timestamp_smoother_top.sv
test/frame_timestamp_smoother_checker.sv
test/frame_timestamp_smoother_top_tb.sv
